[hdl/zvqs_pkg.sv]
// Package for the zone valve queue sequencer.
// Command and state codes, the zone record and the millisecond limit helper.
// No dependencies.
package zvqs_pkg;

	localparam int ZONE_W = 4;
	localparam int DUR_W = 16;
	localparam int MS_W = 27;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_OPEN     = 3'd1,
		ACT_CLOSE    = 3'd2,
		ACT_TOGGLE   = 3'd3,
		ACT_DURATION = 3'd4,
		ACT_MANUAL   = 3'd5
	} action_t;

	localparam logic [1:0] ST_CLOSED  = 2'd0;
	localparam logic [1:0] ST_PENDING = 2'd1;
	localparam logic [1:0] ST_OPEN    = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_OPEN  = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;

	localparam logic REG_ZONES_IN_USE  = 1'b0;
	localparam logic REG_PAUSE_SECONDS = 1'b1;

	localparam logic [DUR_W-1:0] DEFAULT_SECONDS = 16'd300;
	localparam logic [MS_W-1:0] ELAPSED_MAX = 27'h7FF_FFFF;

	typedef struct packed {
		logic [DUR_W-1:0] dur;
		logic [1:0]       st;
	} zrec_t;

	// seconds * 1000 as shift-and-subtract
	function automatic logic [MS_W-1:0] ms_limit(input logic [DUR_W-1:0] secs);
		logic [MS_W-1:0] w;
		w = {{(MS_W - DUR_W){1'b0}}, secs};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

[hdl/zvqs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module zvqs_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/zone_valve_queue_sequencer.sv]
// Zone valve queue sequencer, top level.
// Depends on zvqs_pkg and zvqs_ram.
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | command word: action, zone, value
//  m_*     | out | m_tvalid / m_tready | status word: zone state, valves, phase, depth
//  APB     | in  | psel & penable      | 0x0 zones_in_use, 0x4 pause_seconds
//
// Each command word passes through EXEC, FIN and RES from accept to result; a tick that
// opens the queue head also passes through OPEN, and closing a pending zone through WALK,
// where the queue RAM is walked one entry a cycle to squeeze out the removed zone.
// Zone records sit in a RAM; per-zone valid bits stand in for its reset, so no
// clearing pass is needed after arst_n. A result waits in the output register;
// the next command word is taken meanwhile and only stalls before its own result.
module zone_valve_queue_sequencer #(
	parameter int ZONES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] zone, [19:4] value, [23:20] zero
	input  logic [2:0]  s_tuser,   // [2:0] action
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] zone_state, [17:2] valve_drive, [18] master_on,
	                               // [20:19] phase, [25:21] queue_depth, [31:26] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import zvqs_pkg::*;

	localparam int AW = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int CW = $clog2(ZONES + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_OPEN = 6'b000100,
		S_WALK = 6'b001000,
		S_FIN  = 6'b010000,
		S_RES  = 6'b100000
	} state_t;

	state_t                state_q;
	action_t               action_q;
	logic [ZONE_W-1:0]     zone_q;
	logic [DUR_W-1:0]      value_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         active_q;
	logic [1:0]            phase_q;
	logic [MS_W-1:0]       elapsed_q;
	logic                  override_q;
	logic [4:0]            ziu_q;
	logic [DUR_W-1:0]      pause_q;
	logic [(1<<AW)-1:0]    zvalid_q;
	logic [AW-1:0]         rd_addr_q;
	logic [CW-1:0]         walk_k_q;
	logic                  found_q;
	logic                  m_tvalid_q;
	logic [31:0]           m_tdata_q;

	// queue RAM port signals
	logic                  q_we;
	logic [AW-1:0]         q_waddr;
	logic [ZONE_W-1:0]     q_wdata;
	logic [AW-1:0]         q_raddr;
	logic [ZONE_W-1:0]     q_rdata;
	// zone record RAM port signals
	logic                  z_we;
	logic [AW-1:0]         z_waddr;
	zrec_t                 z_wdata;
	logic [AW-1:0]         z_raddr;
	zrec_t                 z_rdata;

	logic [1:0]            rec_st;
	logic [DUR_W-1:0]      rec_dur;
	logic                  fitted;
	logic                  do_open;
	logic                  do_shut;
	logic                  do_remove;
	logic [MS_W-1:0]       el_inc;
	logic                  close_now;
	logic                  pause_done;
	logic                  walk_match;
	logic                  walk_last;
	logic                  out_free;
	logic [15:0]           drive;

	// ring position k places after the queue head
	function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
			input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(k);
		if (s >= (CW+1)'(ZONES)) begin
			s = s - (CW+1)'(ZONES);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [ZONE_W-1:0] z);
		logic [AW+ZONE_W-1:0] t;
		t = {{AW{1'b0}}, z};
		return t[AW-1:0];
	endfunction

	zvqs_ram #(.WIDTH(ZONE_W), .DEPTH(ZONES)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	zvqs_ram #(.WIDTH($bits(zrec_t)), .DEPTH(ZONES)) u_zone_ram (
		.clk   (clk),
		.we    (z_we),
		.waddr (z_waddr),
		.wdata (z_wdata),
		.raddr (z_raddr),
		.rdata (z_rdata)
	);

	// record of the last read; a never-written zone reads as closed, duration zero (the default)
	assign rec_st  = zvalid_q[rd_addr_q] ? z_rdata.st  : ST_CLOSED;
	assign rec_dur = zvalid_q[rd_addr_q] ? z_rdata.dur : '0;

	assign fitted = ({1'b0, zone_q} < ziu_q) && (int'(zone_q) < ZONES);

	assign do_open = fitted && rec_st == ST_CLOSED && int'(count_q) < ZONES &&
		(action_q == ACT_OPEN || action_q == ACT_TOGGLE);
	assign do_shut = fitted && rec_st == ST_OPEN && phase_q == PH_OPEN &&
		(action_q == ACT_CLOSE || action_q == ACT_TOGGLE);
	assign do_remove = fitted && rec_st == ST_PENDING && action_q == ACT_CLOSE;

	assign el_inc     = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign close_now  = el_inc >= ms_limit((rec_dur == '0) ? DEFAULT_SECONDS : rec_dur);
	assign pause_done = el_inc >= ms_limit(pause_q);

	assign walk_match = !found_q && q_rdata == zone_q;
	assign walk_last  = walk_k_q == CW'(count_q - 1'b1);

	// memory port control
	always_comb begin
		q_raddr = head_q;
		q_we    = 1'b0;
		q_waddr = ring(head_q, count_q);
		q_wdata = zone_q;
		z_raddr = to_addr(zone_q);
		z_we    = 1'b0;
		z_waddr = to_addr(zone_q);
		z_wdata = '{dur: rec_dur, st: rec_st};
		unique case (state_q)
			S_IDLE: begin
				z_raddr = (s_tuser == ACT_TICK) ? active_q : to_addr(s_tdata[3:0]);
			end
			S_EXEC: begin
				case (action_q)
					ACT_TICK: begin
						// head zone record, for the open write that follows
						z_raddr = to_addr(q_rdata);
						if (phase_q == PH_OPEN && close_now) begin
							z_we       = 1'b1;
							z_waddr    = active_q;
							z_wdata.st = ST_CLOSED;
						end
					end
					ACT_OPEN, ACT_CLOSE, ACT_TOGGLE: begin
						if (do_open) begin
							q_we       = 1'b1;
							z_we       = 1'b1;
							z_wdata.st = ST_PENDING;
						end else if (do_shut || do_remove) begin
							z_we       = 1'b1;
							z_wdata.st = ST_CLOSED;
						end
					end
					ACT_DURATION: begin
						if (fitted) begin
							z_we        = 1'b1;
							z_wdata.dur = value_q;
						end
					end
					default: ;
				endcase
			end
			S_OPEN: begin
				z_we       = 1'b1;
				z_waddr    = active_q;
				z_wdata.st = ST_OPEN;
			end
			S_WALK: begin
				// read one ahead, move found tail entries down by one
				q_raddr = ring(head_q, CW'(walk_k_q + 1'b1));
				if (found_q) begin
					q_we    = 1'b1;
					q_waddr = ring(head_q, CW'(walk_k_q - 1'b1));
					q_wdata = q_rdata;
				end
			end
			S_FIN: begin
				z_raddr = to_addr(zone_q);
			end
			S_RES: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= z_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zvalid_q <= '0;
		end else if (z_we) begin
			zvalid_q[z_waddr] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			active_q   <= '0;
			phase_q    <= PH_IDLE;
			elapsed_q  <= '0;
			override_q <= 1'b0;
			walk_k_q   <= '0;
			found_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (action_q)
						ACT_TICK: begin
							case (phase_q)
								PH_IDLE: begin
									if (count_q != '0) begin
										active_q  <= to_addr(q_rdata);
										elapsed_q <= '0;
										phase_q   <= PH_OPEN;
										head_q    <= ring(head_q, CW'(1));
										count_q   <= CW'(count_q - 1'b1);
										state_q   <= S_OPEN;
									end
								end
								PH_OPEN: begin
									elapsed_q <= el_inc;
									if (close_now) begin
										if (pause_q != '0) begin
											phase_q   <= PH_PAUSE;
											elapsed_q <= '0;
										end else begin
											phase_q <= PH_IDLE;
										end
									end
								end
								default: begin
									elapsed_q <= el_inc;
									if (pause_done) begin
										phase_q <= PH_IDLE;
									end
								end
							endcase
						end
						ACT_OPEN, ACT_CLOSE, ACT_TOGGLE: begin
							if (do_open) begin
								count_q <= CW'(count_q + 1'b1);
							end
							if (do_shut) begin
								phase_q <= PH_IDLE;
							end
							if (do_remove && count_q != '0) begin
								walk_k_q <= '0;
								found_q  <= 1'b0;
								state_q  <= S_WALK;
							end
						end
						ACT_MANUAL: begin
							override_q <= value_q[0];
						end
						default: ;
					endcase
				end
				S_OPEN: begin
					state_q <= S_FIN;
				end
				S_WALK: begin
					if (walk_match) begin
						found_q <= 1'b1;
					end
					if (walk_last) begin
						if (found_q || walk_match) begin
							count_q <= CW'(count_q - 1'b1);
						end
						state_q <= S_FIN;
					end else begin
						walk_k_q <= CW'(walk_k_q + 1'b1);
					end
				end
				S_FIN: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			action_q <= action_t'(s_tuser);
			zone_q   <= s_tdata[3:0];
			value_q  <= s_tdata[19:4];
		end
	end

	assign s_tready = state_q == S_IDLE;

	// output register
	assign out_free = !m_tvalid_q || m_tready;
	assign drive    = (phase_q == PH_OPEN) ? (16'd1 << active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_RES && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			m_tdata_q <= {6'd0, 5'(count_q), phase_q,
				override_q || phase_q == PH_OPEN, drive,
				(int'(zone_q) < ZONES) ? rec_st : ST_CLOSED};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ziu_q   <= 5'd16;
			pause_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ZONES_IN_USE:  ziu_q   <= pwdata[4:0];
				REG_PAUSE_SECONDS: pause_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ZONES_IN_USE:  prdata = {27'd0, ziu_q};
			REG_PAUSE_SECONDS: prdata = {16'd0, pause_q};
			default:           prdata = '0;
		endcase
	end

	assign pready = 1'b1;

endmodule
